FILE: hdl/kto_pkg.sv
`timescale 1ns / 1ps
// kto_pkg: command codes, field widths and shared structs of the key to owner table.
// No dependencies; kto_ctrl, key_to_owner_table and the testbench import it.
package kto_pkg;

   localparam int KEY_W  = 32;
   localparam int RANK_W = 16;
   localparam int CMD_W  = 2;
   localparam int USED_W = 5;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // one finished result, handed from the sequencer to the output register
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              hit;
      logic              full_drop;
      logic [USED_W-1:0] used_entries;
   } kto_result_type;

   // strobes from the sequencer to the two table memories
   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic rank_we;
   } kto_mem_ctl_type;

endpackage

FILE: hdl/kto_ram.sv
`timescale 1ns / 1ps
// kto_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module kto_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/kto_ctrl.sv
`timescale 1ns / 1ps
// kto_ctrl: sequencer of the key to owner table; scans the key memory with one
// shared comparator, then appends, updates or moves the last entry. Uses kto_pkg.
module kto_ctrl
   import kto_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CntW  = $clog2(ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [RANK_W-1:0]   req_new_rank,
   input  logic [RANK_W-1:0]   default_rank,
   input  logic                out_free,
   output logic                res_load,
   output kto_result_type      res,
   output kto_mem_ctl_type     mem_ctl,
   output logic [AddrW-1:0]    rd_addr,
   output logic [AddrW-1:0]    wr_addr,
   output logic [KEY_W-1:0]    key_wdata,
   output logic [RANK_W-1:0]   rank_wdata,
   input  logic [KEY_W-1:0]    key_rdata,
   input  logic [RANK_W-1:0]   rank_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_MOVE
   } state_type;

   state_type           state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [CntW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [AddrW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [AddrW-1:0]    match_idx_ff, match_idx_in;
   logic                hit_ff, hit_in;
   logic [RANK_W-1:0]   found_rank_ff, found_rank_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [RANK_W-1:0]   new_rank_ff, new_rank_in;

   logic                  full;
   logic [CntW-1:0]       last_cnt;
   logic [RANK_W-1:0]     res_rank;
   logic                  res_hit;
   logic                  res_drop;
   logic [CntW+USED_W-1:0] used_ext;

   assign full     = (count_ff == CntW'(ENTRIES));
   assign last_cnt = count_ff - 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      match_idx_in  = match_idx_ff;
      hit_in        = hit_ff;
      found_rank_in = found_rank_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      new_rank_in   = new_rank_ff;
      mem_ctl       = '0;
      rd_addr       = rd_ptr_ff[AddrW-1:0];
      wr_addr       = match_idx_ff;
      key_wdata     = key_ff;
      rank_wdata    = new_rank_ff;
      res_load      = 1'b0;
      res_rank      = '0;
      res_hit       = 1'b0;
      res_drop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_cmd;
               key_in       = req_key;
               new_rank_in  = req_new_rank;
               rd_ptr_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // compare the entry read last cycle while the next one is read
            if (cmp_valid_ff && (key_rdata == key_ff)) begin
               hit_in        = 1'b1;
               match_idx_in  = cmp_idx_ff;
               found_rank_in = rank_rdata;
               cmp_valid_in  = 1'b0;
               state_in      = ST_ACT;
            end else if (rd_ptr_ff < count_ff) begin
               mem_ctl.rd_en = 1'b1;
               cmp_valid_in  = 1'b1;
               cmp_idx_in    = rd_ptr_ff[AddrW-1:0];
               rd_ptr_in     = rd_ptr_ff + 1'b1;
            end else begin
               hit_in       = 1'b0;
               cmp_valid_in = 1'b0;
               state_in     = ST_ACT;
            end
         end
         ST_ACT: begin
            if ((cmd_ff == CMD_REMOVE) && hit_ff) begin
               // fetch the last entry to fill the hole
               mem_ctl.rd_en = 1'b1;
               rd_addr       = last_cnt[AddrW-1:0];
               state_in      = ST_MOVE;
            end else if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     res_hit  = hit_ff;
                     res_rank = hit_ff ? found_rank_ff : default_rank;
                     if (!hit_ff) begin
                        if (full) begin
                           res_drop = 1'b1;
                        end else begin
                           mem_ctl.key_we  = 1'b1;
                           mem_ctl.rank_we = 1'b1;
                           wr_addr         = count_ff[AddrW-1:0];
                           rank_wdata      = default_rank;
                           count_in        = count_ff + 1'b1;
                        end
                     end
                  end
                  CMD_SET: begin
                     res_hit = hit_ff;
                     if (hit_ff) begin
                        mem_ctl.rank_we = 1'b1;
                     end else if (full) begin
                        res_drop = 1'b1;
                     end else begin
                        mem_ctl.key_we  = 1'b1;
                        mem_ctl.rank_we = 1'b1;
                        wr_addr         = count_ff[AddrW-1:0];
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     // remove that missed, or unused code: table unchanged
                  end
               endcase
            end
         end
         ST_MOVE: begin
            if (out_free) begin
               mem_ctl.key_we  = 1'b1;
               mem_ctl.rank_we = 1'b1;
               key_wdata       = key_rdata;
               rank_wdata      = rank_rdata;
               count_in        = last_cnt;
               res_hit         = 1'b1;
               res_load        = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // count after the command, reported modulo the field width
   assign used_ext         = {{USED_W{1'b0}}, count_in};
   assign res.rank         = res_rank;
   assign res.hit          = res_hit;
   assign res.full_drop    = res_drop;
   assign res.used_entries = used_ext[USED_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_idx_ff  <= match_idx_in;
      hit_ff        <= hit_in;
      found_rank_ff <= found_rank_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      new_rank_ff   <= new_rank_in;
   end

endmodule

FILE: hdl/key_to_owner_table.sv
`timescale 1ns / 1ps
// key_to_owner_table: top level; default rank register, output register,
// table memories (kto_ram) and the search sequencer (kto_ctrl). Uses kto_pkg.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+----------------------------------------
//  req     | in        | req_valid/req_ready  | req_cmd, req_key, req_new_rank
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_rank, rsp_hit, rsp_full_drop,
//          |           |                      | rsp_used_entries
//  csr     | in        | csr_wr_en            | csr_wr_data (default rank)
//
// Steps: a beat is taken in ST_IDLE, ST_SCAN reads and compares the stored keys in turn,
// ST_ACT answers or writes, and a remove that hits adds ST_MOVE to fill the hole.
// One request is in work at a time.
// Reset (synchronous, active high) empties the table and clears the default rank;
// no memory clearing pass is needed, only entries below the count are read.
// Stalls: a finished result waits in the output register; a new request is taken
// meanwhile, and only the next result waits for rsp_ready.
module key_to_owner_table
   import kto_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic        [CMD_W-1:0]  req_cmd,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic        [RANK_W-1:0] req_new_rank,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [RANK_W-1:0] rsp_rank,
   output logic                     rsp_hit,
   output logic                     rsp_full_drop,
   output logic        [USED_W-1:0] rsp_used_entries,
   input  logic                     csr_wr_en,
   input  logic        [RANK_W-1:0] csr_wr_data
);

   logic [RANK_W-1:0] default_rank_ff;
   logic              rsp_valid_ff;
   kto_result_type    rsp_ff;

   logic              out_free;
   logic              res_load;
   kto_result_type    res;
   kto_mem_ctl_type   mem_ctl;
   logic [AddrW-1:0]  rd_addr;
   logic [AddrW-1:0]  wr_addr;
   logic [KEY_W-1:0]  key_wdata;
   logic [RANK_W-1:0] rank_wdata;
   logic [KEY_W-1:0]  key_rdata;
   logic [RANK_W-1:0] rank_rdata;

   // the output register is free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   kto_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_key      (req_key),
      .req_new_rank (req_new_rank),
      .default_rank (default_rank_ff),
      .out_free     (out_free),
      .res_load     (res_load),
      .res          (res),
      .mem_ctl      (mem_ctl),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .key_wdata    (key_wdata),
      .rank_wdata   (rank_wdata),
      .key_rdata    (key_rdata),
      .rank_rdata   (rank_rdata)
   );

   // key and rank columns share addresses; both read in the same cycle
   kto_ram #(
      .WIDTH (KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   kto_ram #(
      .WIDTH (RANK_W),
      .DEPTH (ENTRIES)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.rank_we),
      .wr_addr (wr_addr),
      .wr_data (rank_wdata),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rank_rdata)
   );

   // hold the default rank; load on every write strobe
   // hold a result until taken; load when the sequencer finishes a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         default_rank_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            default_rank_ff <= csr_wr_data;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank         = rsp_ff.rank;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_full_drop    = rsp_ff.full_drop;
   assign rsp_used_entries = rsp_ff.used_entries;

   // a result never overwrites one that is still waiting
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting result");

   // a dropped append means the key was absent
   a_drop_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit && rsp_full_drop))
      else $error("result flags both hit and drop");

   // a drop only happens with the table at capacity
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_drop) |-> (rsp_used_entries == USED_W'(ENTRIES)))
      else $error("drop reported below capacity");

   // one request at a time: the sequencer is busy after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a search is in progress");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for key_to_owner_table (lookup, set and remove on the table).
// Uses kto_pkg for the widths, command codes and result struct; needs nothing but the RTL.
module testbench
   import kto_pkg::*;
();

   localparam int TABLE_DEPTH = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   // the fourth command code has no meaning; the table must leave it alone
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_type;

   // one row of the directed stimulus; "typed" rows carry the result read off by hand
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [RANK_W-1:0] new_rank;
      logic              typed;
      kto_result_type    want;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic        [CMD_W-1:0]  req_cmd = CMD_LOOKUP;
   logic signed [KEY_W-1:0]  req_key = '0;
   logic        [RANK_W-1:0] req_new_rank = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic        [RANK_W-1:0] rsp_rank;
   logic                     rsp_hit;
   logic                     rsp_full_drop;
   logic        [USED_W-1:0] rsp_used_entries;
   logic                     csr_wr_en = 1'b0;
   logic        [RANK_W-1:0] csr_wr_data = '0;

   // bench copy of the table, advanced once per accepted request beat
   logic [KEY_W-1:0]  owner_keys  [TABLE_DEPTH];
   logic [RANK_W-1:0] owner_ranks [TABLE_DEPTH];
   int                owner_count = 0;
   logic [RANK_W-1:0] dflt_rank = '0;

   // results still owed by the block, oldest first
   kto_result_type pending_rsp [$];

   int  mismatches = 0;
   int  beats_checked = 0;
   int  hits_seen = 0;
   int  drops_seen = 0;
   int  settings_written = 0;
   int  input_stall_cycles = 0;
   int  burst_left = 0;
   bit  hold_rsp_req = 1'b0;

   key_to_owner_table #(.ENTRIES(TABLE_DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_new_rank     (req_new_rank),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank         (rsp_rank),
      .rsp_hit          (rsp_hit),
      .rsp_full_drop    (rsp_full_drop),
      .rsp_used_entries (rsp_used_entries),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Append a pair at the end of the bench table; report false when it is full.
   function automatic bit stash_pair(logic [KEY_W-1:0] k, logic [RANK_W-1:0] r);
      if (owner_count >= TABLE_DEPTH)
         return 1'b0;
      owner_keys[owner_count]  = k;
      owner_ranks[owner_count] = r;
      owner_count++;
      return 1'b1;
   endfunction

   // Work out the result of one request and update the bench table to match.
   function automatic kto_result_type predict_owner(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                                    logic [RANK_W-1:0] nr);
      kto_result_type res;
      int slot;
      res  = '0;
      slot = owner_count;
      // linear search from entry 0; the first match wins
      for (int i = 0; i < owner_count; i++)
         if (slot == owner_count && owner_keys[i] == k)
            slot = i;
      case (c)
         CMD_LOOKUP: begin
            if (slot < owner_count) begin
               res.hit  = 1'b1;
               res.rank = owner_ranks[slot];
            end else begin
               // a miss still answers with the default, even when the append is dropped
               res.rank      = dflt_rank;
               res.full_drop = !stash_pair(k, dflt_rank);
            end
         end
         CMD_SET: begin
            if (slot < owner_count) begin
               res.hit           = 1'b1;
               owner_ranks[slot] = nr;
            end else begin
               res.full_drop = !stash_pair(k, nr);
            end
         end
         CMD_REMOVE: begin
            // move the last entry into the freed slot and shrink
            if (slot < owner_count) begin
               res.hit           = 1'b1;
               owner_keys[slot]  = owner_keys[owner_count-1];
               owner_ranks[slot] = owner_ranks[owner_count-1];
               owner_count--;
            end
         end
         default: ;
      endcase
      res.used_entries = USED_W'(owner_count);
      return res;
   endfunction

   function automatic dir_row_type dir_row(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                        logic [RANK_W-1:0] nr, bit typed, logic [RANK_W-1:0] rk,
                                        bit ht, bit dr, logic [USED_W-1:0] used);
      dir_row_type r;
      r.cmd               = c;
      r.key               = k;
      r.new_rank          = nr;
      r.typed             = typed;
      r.want.rank         = rk;
      r.want.hit          = ht;
      r.want.full_drop    = dr;
      r.want.used_entries = used;
      return r;
   endfunction

   function automatic void compare_field(string what, logic [RANK_W-1:0] want,
                                         logic [RANK_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Offer one request beat and hold it until accepted. Bursts of random length are
   // separated by random gaps; the gap is taken before the first beat of a burst.
   task automatic send_beat(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                            input logic [RANK_W-1:0] nr, input bit typed,
                            input kto_result_type want);
      int gap;
      kto_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_cmd      <= c;
      req_key      <= k;
      req_new_rank <= nr;
      // values read right after the edge are the ones the edge sampled
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = predict_owner(c, k, nr);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait until every owed result is back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the default rank; only called while the block is idle.
   task automatic write_default(input logic [RANK_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dflt_rank = v;
      settings_written++;
   endtask

   // Random requests over a pool of keys, so that hits, full-table drops and
   // removes that empty the table all come up; a few keys are pure noise.
   task automatic run_phase(input int n_items, input int pool_size, input int lookup_pct,
                            input int set_pct, input int remove_pct);
      logic [KEY_W-1:0]  pool [$];
      logic [CMD_W-1:0]  c;
      logic [KEY_W-1:0]  k;
      logic [RANK_W-1:0] nr;
      int roll;
      for (int i = 0; i < pool_size; i++)
         pool.push_back($urandom);
      // keep the extreme keys in every pool
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7FFF_FFFF;
      pool[2] = 32'hFFFF_FFFF;
      pool[3] = 32'h0000_0000;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < lookup_pct)
            c = CMD_LOOKUP;
         else if (roll < lookup_pct + set_pct)
            c = CMD_SET;
         else if (roll < lookup_pct + set_pct + remove_pct)
            c = CMD_REMOVE;
         else
            c = CMD_UNUSED;
         if ($urandom_range(0, 99) < 88)
            k = pool[$urandom_range(0, pool_size - 1)];
         else
            k = $urandom;
         case ($urandom_range(0, 9))
            0:       nr = '0;
            1:       nr = '1;
            default: nr = RANK_W'($urandom);
         endcase
         send_beat(c, k, nr, 1'b0, '0);
      end
   endtask

   // Result side: check each beat against the oldest owed result, and count how
   // often the block pushed back on requests.
   always @(posedge clock) begin : rsp_check
      kto_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result beat with nothing owed: rank %h hit %b drop %b used %0d",
                     $time, rsp_rank, rsp_hit, rsp_full_drop, rsp_used_entries);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("rank", want.rank, rsp_rank);
            compare_field("hit", RANK_W'(want.hit), RANK_W'(rsp_hit));
            compare_field("full_drop", RANK_W'(want.full_drop), RANK_W'(rsp_full_drop));
            compare_field("used_entries", RANK_W'(want.used_entries),
                          RANK_W'(rsp_used_entries));
            beats_checked++;
            hits_seen  += want.hit;
            drops_seen += want.full_drop;
         end
      end
      if (!reset && req_valid && req_ready !== 1'b1)
         input_stall_cycles++;
   end

   // Receiver: switch at random between stall patterns; on request,
   // hold off for one long stretch so the block backs up into the request side.
   initial begin : rsp_side
      rx_mode_type mode;
      int          mode_left;
      logic [7:0]  stall_mask;
      mode       = RX_STREAM;
      mode_left  = 0;
      stall_mask = 8'hA5;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_rsp_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode       = rx_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(32, 400);
               stall_mask = 8'($urandom_range(1, 255));
            end
            mode_left--;
            case (mode)
               RX_STREAM: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  rsp_ready  <= stall_mask[0];
                  stall_mask = {stall_mask[0], stall_mask[7:1]};
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      dir_row_type rows [$];
      // walk the table through its corners with the reset default rank of zero
      rows.push_back(dir_row(CMD_LOOKUP, 32'h8000_0000, 16'h0000, 1, 16'h0000, 0, 0, 5'd1));
      rows.push_back(dir_row(CMD_LOOKUP, 32'h8000_0000, 16'hFFFF, 1, 16'h0000, 1, 0, 5'd1));
      rows.push_back(dir_row(CMD_SET,    32'h7FFF_FFFF, 16'hFFFF, 1, 16'h0000, 0, 0, 5'd2));
      rows.push_back(dir_row(CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1, 16'hFFFF, 1, 0, 5'd2));
      rows.push_back(dir_row(CMD_SET,    32'h7FFF_FFFF, 16'h0001, 1, 16'h0000, 1, 0, 5'd2));
      rows.push_back(dir_row(CMD_UNUSED, 32'h7FFF_FFFF, 16'hFFFF, 1, 16'h0000, 0, 0, 5'd2));
      rows.push_back(dir_row(CMD_REMOVE, 32'h0000_0000, 16'h0000, 1, 16'h0000, 0, 0, 5'd2));
      // remove of entry 0 pulls the last entry into its slot
      rows.push_back(dir_row(CMD_REMOVE, 32'h8000_0000, 16'h0000, 1, 16'h0000, 1, 0, 5'd1));
      rows.push_back(dir_row(CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1, 16'h0001, 1, 0, 5'd1));
      rows.push_back(dir_row(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 16'h0000, 0, 0, 5'd2));
      // fill to capacity
      rows.push_back(dir_row(CMD_SET, 32'h0000_0000, 16'h0000, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h0000_0001, 16'hAAAA, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h5555_5555, 16'h5555, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'hAAAA_AAAA, 16'h8000, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h1234_5678, 16'h7FFF, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h8765_4321, 16'h0F0F, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'hFFFF_FFFE, 16'hF0F0, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h8000_0001, 16'h0001, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h7FFF_FFFE, 16'hFFFE, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h0000_FFFF, 16'h1234, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'hFFFF_0000, 16'hCDEF, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h0001_0000, 16'h00FF, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'hDEAD_BEEF, 16'hFF00, 0, '0, 0, 0, '0));
      rows.push_back(dir_row(CMD_SET, 32'h0F0F_0F0F, 16'h3C3C, 0, '0, 0, 0, '0));
      // full table: lookup answers the default and flags the drop, set drops too
      rows.push_back(dir_row(CMD_LOOKUP, 32'h1357_9BDF, 16'h0000, 1, 16'h0000, 0, 1, 5'd16));
      rows.push_back(dir_row(CMD_SET,    32'h2468_ACE0, 16'hBEEF, 1, 16'h0000, 0, 1, 5'd16));
      rows.push_back(dir_row(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1, 16'h0000, 1, 0, 5'd15));

      // hold reset, then release it at an edge
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_beat(rows[i].cmd, rows[i].key, rows[i].new_rank, rows[i].typed, rows[i].want);
      drain();

      // top default; the receiver stops for a long stretch at the start of this phase
      write_default(16'hFFFF);
      hold_rsp_req = 1'b1;
      run_phase(345, 20, 40, 30, 27);
      drain();

      // zero default, big key pool and few removes: the table sits at full
      write_default(16'h0000);
      run_phase(345, 40, 45, 45, 7);
      drain();

      // few keys and many removes: the table runs empty, removes miss
      write_default(RANK_W'($urandom));
      run_phase(345, 8, 25, 20, 52);
      drain();

      write_default(16'h8000);
      run_phase(345, 30, 35, 30, 32);
      drain();

      write_default(RANK_W'($urandom));
      run_phase(345, 24, 40, 30, 27);
      drain();

      // give a stray late beat time to show up
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("covered %0d result beats over %0d default-rank settings: %0d hits, %0d drops",
               beats_checked, settings_written, hits_seen, drops_seen);
      $display("request side held off for %0d cycles; %0d mismatching fields",
               input_stall_cycles, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // stop a hung run; a correct run needs well under a tenth of this
   initial begin : watchdog
      #40_000_000;
      $display("timeout with %0d results still owed", pending_rsp.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
